/* src/bmp565_pkg.sv */
package bmp565_pkg;

	// parser phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_PIXELS = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// final status codes
	localparam logic [2:0] ST_DRAWN      = 3'd0;
	localparam logic [2:0] ST_BAD_PLANES = 3'd1;
	localparam logic [2:0] ST_BAD_DEPTH  = 3'd2;
	localparam logic [2:0] ST_COMPRESSED = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
	localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

	// register reset values
	localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd128;
	localparam logic [7:0] SCREEN_HEIGHT_RST = 8'd160;

	// panel commands
	localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
	localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
	localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

	// header layout
	localparam logic [5:0] HDR_LAST_BYTE = 6'd33;
	localparam logic [31:0] HDR_BYTES    = 32'd34;
	localparam logic [31:0] MAX_WIDTH    = 32'd1280;
	localparam logic [7:0] DEPTH_24      = 8'd24;

	// results in the window sequence that opens a row
	localparam logic [3:0] WIN_RESULTS = 4'd11;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] bus_byte;
		logic [2:0] status;
	} result_t;

	// bgr888 to rgb565
	function automatic logic [15:0] to_rgb565(input logic [7:0] blue, input logic [7:0] green,
			input logic [7:0] red);
		to_rgb565 = {red[7:3], green[7:2], blue[7:3]};
	endfunction

endpackage

/* src/bmp24_to_lcd_rgb565_streamer.sv */
// Streams an uncompressed 24-bit BMP file, one byte per input word (file_start set on
// byte 0), and turns it into RGB565 panel bus bytes. Bytes 26..33 of the header are
// checked (1 plane, 24 bpp, no compression) as are width 1..1280 and nonzero height; a
// failing header gives one status word on byte 33. A good image is centered and cropped
// to the screen size held in the configuration registers and drawn bottom-up: the first
// pixel byte of every shown row emits an 11-word window sequence (0x2A, 0x2B, 0x2C with
// address bytes), every third byte of a pixel emits the high and low color words, and the
// last pixel of the top shown row adds a final status word. The input word sits in a
// single input register while its output words leave through one output register at one
// word per cycle when the output is not stalled. A byte that emits no word retires
// without waiting on the output; one that emits words (2 for a completed pixel, 3 for
// the final one, 11 at a row start) is held until its last word is loaded. Configuration
// writes are always taken and should only be made while no word is in flight.
module bmp24_to_lcd_rgb565_streamer
	import bmp565_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// file byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] file_byte
	input  logic        s_tuser,   // [0] file_start
	// panel word output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] bus_byte, [10:8] status, [15:11] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last_of_run
);

	// configuration registers
	logic [7:0] scr_w_q, scr_h_q;
	logic [6:0] col_off_q, row_off_q;

	// parser state
	logic [2:0]  phase_q;
	logic [31:0] pos_q, offset_q, img_w_q, img_h_q;
	logic [7:0]  row_q;
	logic [11:0] bir_q;
	logic [1:0]  k_q;
	logic [15:0] held_q;
	logic [2:0]  fault_q;

	// input register
	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// output register and burst index
	logic       out_valid_q;
	result_t    out_res_q;
	logic       out_last_q;
	logic [3:0] idx_q;

	// state as seen by the held word (a file start clears it)
	logic [2:0]  e_phase;
	logic [31:0] e_pos, e_off, e_img_w, e_img_h;
	logic [7:0]  e_row;
	logic [11:0] e_bir;
	logic [1:0]  e_k;
	logic [15:0] e_held;
	logic [2:0]  e_fault;

	// geometry
	logic [7:0]  scr_w, scr_h;
	logic [10:0] bw;
	logic        w_clip, h_big;
	logic [7:0]  w8, xs, xe, first_row, row_init;
	logic [9:0]  w3;
	logic [11:0] iw;
	logic [31:0] skip_rows;
	logic [43:0] skip_prod;
	logic [44:0] start_sum;
	logic [31:0] start_pos;

	// per word decode
	logic        pix_call, win, pix, fin, fault_res;
	logic [3:0]  n_res;
	logic [15:0] rgb;
	logic [7:0]  col_a, col_b, row_a;
	result_t     cur_res;
	logic        cur_last;

	// next state
	logic [2:0]  n_phase;
	logic [31:0] n_pos, n_off, n_img_w, n_img_h;
	logic [7:0]  n_row;
	logic [11:0] n_bir;
	logic [1:0]  n_k;
	logic [15:0] n_held;
	logic [2:0]  n_fault;
	logic [2:0]  hdr_fault;
	logic [5:0]  hpos;
	logic [1:0]  hsel;

	// handshake
	logic out_free, load, retire, in_take;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q   <= SCREEN_WIDTH_RST;
			scr_h_q   <= SCREEN_HEIGHT_RST;
			col_off_q <= '0;
			row_off_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  scr_w_q <= cfg_data;
				REG_SCREEN_HEIGHT: scr_h_q <= cfg_data;
				REG_COLUMN_OFFSET: col_off_q <= cfg_data[6:0];
				REG_ROW_OFFSET:    row_off_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// effective state for the held word
	always_comb begin
		e_phase = start_s1 ? PH_HEADER : phase_q;
		e_pos   = start_s1 ? '0 : pos_q;
		e_off   = start_s1 ? '0 : offset_q;
		e_img_w = start_s1 ? '0 : img_w_q;
		e_img_h = start_s1 ? '0 : img_h_q;
		e_row   = start_s1 ? '0 : row_q;
		e_bir   = start_s1 ? '0 : bir_q;
		e_k     = start_s1 ? '0 : k_q;
		e_held  = start_s1 ? '0 : held_q;
		e_fault = start_s1 ? '0 : fault_q;
	end

	// screen geometry, centering and cropping
	always_comb begin
		scr_w     = (scr_w_q == 8'd0) ? 8'd1 : scr_w_q;
		scr_h     = (scr_h_q == 8'd0) ? 8'd1 : scr_h_q;
		bw        = e_img_w[10:0];
		w_clip    = bw > {3'b000, scr_w};
		w8        = w_clip ? scr_w : bw[7:0];
		xs        = w_clip ? 8'd0 : 8'(({3'b000, scr_w} - bw) >> 1);
		xe        = w_clip ? 8'(scr_w - 8'd1) : 8'(xs + bw[7:0] - 8'd1);
		w3        = {1'b0, w8, 1'b0} + {2'b00, w8};
		iw        = 12'(({2'b00, bw} + {1'b0, bw, 1'b0} + 13'd3) & ~13'd3);
		h_big     = e_img_h > {24'd0, scr_h};
		first_row = h_big ? 8'd0 : 8'((scr_h - e_img_h[7:0]) >> 1);
		row_init  = h_big ? 8'(scr_h - 8'd1) : 8'(first_row + e_img_h[7:0] - 8'd1);
		skip_rows = h_big ? (e_img_h - {24'd0, scr_h}) : 32'd0;
		skip_prod = {12'd0, skip_rows} * {32'd0, iw};
		start_sum = {1'b0, skip_prod} + {13'd0, e_off};
		if (start_sum < {13'd0, HDR_BYTES}) begin
			start_pos = HDR_BYTES;
		end else if (start_sum[44:32] != 13'd0) begin
			start_pos = '1;
		end else begin
			start_pos = start_sum[31:0];
		end
	end

	// which words the held byte emits
	always_comb begin
		hpos      = e_pos[5:0];
		// byte lane of a multi-byte header field
		hsel      = hpos[1:0] - 2'd2;
		pix_call  = (e_phase == PH_PIXELS) || ((e_phase == PH_SKIP) && (e_pos == e_off));
		win       = pix_call && (e_bir == 12'd0);
		pix       = pix_call && (e_bir < {2'b00, w3}) && (e_k == 2'd2);
		fin       = pix && (e_bir == {2'b00, w3} - 12'd1) && (e_row <= first_row);
		hdr_fault = e_fault;
		if (e_phase == PH_HEADER) begin
			if ((hpos == 6'd26 && byte_s1 != 8'd1) || (hpos == 6'd27 && byte_s1 != 8'd0)) begin
				if (hdr_fault == ST_DRAWN) hdr_fault = ST_BAD_PLANES;
			end
			if ((hpos == 6'd28 && byte_s1 != DEPTH_24) || (hpos == 6'd29 && byte_s1 != 8'd0)) begin
				if (hdr_fault == ST_DRAWN) hdr_fault = ST_BAD_DEPTH;
			end
			if (hpos >= 6'd30 && hpos <= 6'd33 && byte_s1 != 8'd0) begin
				if (hdr_fault == ST_DRAWN) hdr_fault = ST_COMPRESSED;
			end
			if (hpos == HDR_LAST_BYTE && hdr_fault == ST_DRAWN &&
					(e_img_w == 32'd0 || e_img_w > MAX_WIDTH || e_img_h == 32'd0)) begin
				hdr_fault = ST_BAD_SIZE;
			end
		end
		fault_res = (e_phase == PH_HEADER) && (hpos == HDR_LAST_BYTE) && (hdr_fault != ST_DRAWN);
		if (fault_res) begin
			n_res = 4'd1;
		end else if (win) begin
			n_res = WIN_RESULTS;
		end else if (pix) begin
			n_res = fin ? 4'd3 : 4'd2;
		end else begin
			n_res = 4'd0;
		end
	end

	// word selected by the burst index
	always_comb begin
		rgb      = to_rgb565(e_held[7:0], e_held[15:8], byte_s1);
		col_a    = 8'({1'b0, col_off_q} + xs);
		col_b    = 8'({1'b0, col_off_q} + xe);
		row_a    = 8'({1'b0, row_off_q} + e_row);
		cur_res  = '{kind: KIND_DATA, bus_byte: 8'd0, status: ST_DRAWN};
		cur_last = (idx_q == n_res - 4'd1);
		if (fault_res) begin
			cur_res = '{kind: KIND_STATUS, bus_byte: 8'd0, status: hdr_fault};
		end else if (win) begin
			case (idx_q)
				4'd0:    cur_res = '{kind: KIND_CMD, bus_byte: CMD_COL_ADDR, status: ST_DRAWN};
				4'd2:    cur_res.bus_byte = col_a;
				4'd4:    cur_res.bus_byte = col_b;
				4'd5:    cur_res = '{kind: KIND_CMD, bus_byte: CMD_ROW_ADDR, status: ST_DRAWN};
				4'd7:    cur_res.bus_byte = row_a;
				4'd9:    cur_res.bus_byte = row_a;
				4'd10:   cur_res = '{kind: KIND_CMD, bus_byte: CMD_MEM_WR, status: ST_DRAWN};
				default: cur_res.bus_byte = 8'd0;
			endcase
		end else begin
			case (idx_q)
				4'd0:    cur_res.bus_byte = rgb[15:8];
				4'd1:    cur_res.bus_byte = rgb[7:0];
				default: cur_res = '{kind: KIND_STATUS, bus_byte: 8'd0, status: ST_DRAWN};
			endcase
		end
	end

	// state after the held byte
	always_comb begin
		n_phase = e_phase;
		n_pos   = e_pos;
		n_off   = e_off;
		n_img_w = e_img_w;
		n_img_h = e_img_h;
		n_row   = e_row;
		n_bir   = e_bir;
		n_k     = e_k;
		n_held  = e_held;
		n_fault = e_fault;
		// header fields
		if (e_phase == PH_HEADER) begin
			n_fault = hdr_fault;
			if (hpos >= 6'd10 && hpos <= 6'd13) begin
				n_off[{hsel, 3'b000} +: 8] = e_off[{hsel, 3'b000} +: 8] | byte_s1;
			end else if (hpos >= 6'd18 && hpos <= 6'd21) begin
				n_img_w[{hsel, 3'b000} +: 8] = e_img_w[{hsel, 3'b000} +: 8] | byte_s1;
			end else if (hpos >= 6'd22 && hpos <= 6'd25) begin
				n_img_h[{hsel, 3'b000} +: 8] = e_img_h[{hsel, 3'b000} +: 8] | byte_s1;
			end
			if (hpos == HDR_LAST_BYTE) begin
				if (fault_res) begin
					n_phase = PH_DONE;
				end else begin
					n_off   = start_pos;
					n_row   = row_init;
					n_bir   = '0;
					n_k     = '0;
					n_held  = '0;
					n_phase = PH_SKIP;
				end
			end
		end
		// position counts in header and skip phases, saturating
		if ((e_phase == PH_HEADER || e_phase == PH_SKIP) && e_pos != 32'hFFFF_FFFF) begin
			n_pos = e_pos + 32'd1;
		end
		// pixel bytes
		if (pix_call) begin
			n_phase = PH_PIXELS;
			if (e_bir < {2'b00, w3}) begin
				case (e_k)
					2'd0:    n_held = {8'd0, byte_s1};
					2'd1:    n_held = {byte_s1, e_held[7:0]};
					default: n_held = e_held;
				endcase
			end
			if (fin) begin
				n_phase = PH_DONE;
			end else if (e_bir + 12'd1 >= iw) begin
				n_bir = '0;
				n_k   = '0;
				if (e_row != 8'd0) n_row = e_row - 8'd1;
			end else begin
				n_bir = e_bir + 12'd1;
				n_k   = (e_k == 2'd2) ? 2'd0 : e_k + 2'd1;
			end
		end
	end

	// handshake between input register and output register
	assign out_free = !out_valid_q || m_tready;
	assign load     = in_valid_s1 && (n_res != 4'd0) && out_free;
	assign retire   = in_valid_s1 && ((n_res == 4'd0) || (load && cur_last));
	assign s_tready = !in_valid_s1 || retire;
	assign in_take  = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_take) begin
			in_valid_s1 <= 1'b1;
		end else if (retire) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// parser state update when a word retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			offset_q <= '0;
			img_w_q  <= '0;
			img_h_q  <= '0;
			row_q    <= '0;
			bir_q    <= '0;
			k_q      <= '0;
			held_q   <= '0;
			fault_q  <= '0;
		end else if (retire) begin
			phase_q  <= n_phase;
			pos_q    <= n_pos;
			offset_q <= n_off;
			img_w_q  <= n_img_w;
			img_h_q  <= n_img_h;
			row_q    <= n_row;
			bir_q    <= n_bir;
			k_q      <= n_k;
			held_q   <= n_held;
			fault_q  <= n_fault;
		end
	end

	// burst index and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= cur_last ? 4'd0 : idx_q + 4'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= cur_res;
			out_last_q <= cur_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_res_q.status, out_res_q.bus_byte};
	assign m_tuser  = out_res_q.kind;
	assign m_tlast  = out_last_q;

endmodule
